/* hw/rtl/lrb_pkg.sv */
package lrb_pkg;

	// default sizes of the store
	localparam int BUFFER_SIZE_DEF = 1024;
	localparam int MAX_LINE_DEF    = 64;

	// operation codes of an input beat
	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_POP   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// result kinds of an output beat
	localparam logic [1:0] RK_STATUS = 2'd0;
	localparam logic [1:0] RK_BYTE   = 2'd1;
	localparam logic [1:0] RK_EMPTY  = 2'd2;
	localparam logic [1:0] RK_CLEAR  = 2'd3;

	localparam logic [7:0] NEWLINE = 8'h0A;

	// one result beat as it travels from the sequencer to the output register
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic        last;
		logic        accepted;
		logic [10:0] discarded;
		logic [10:0] used;
	} result_t;

endpackage

/* hw/rtl/line_ring_buffer_drop_oldest_core.sv */
// Channel  Handshake            Payload
// in       in_valid / in_stall  operation, line_length, data_byte
// out      out_valid/out_stall  result_kind, data_byte_res, last, accepted,
//                               lines_discarded, used_bytes
//
// Push byte, clear, a rejected begin push and a pop on an empty store are answered
// from idle and can follow each other in every cycle while the output is not stalled.
// A taken begin push drops oldest lines byte by byte until the new line fits;
// a pop emits its line byte by byte: each byte is read from the store port, then inspected.
// arst_n clears pointers, fill count and pending count; the store needs no clearing.
// A stalled output holds its beat and stalls the input until that beat leaves.
module line_ring_buffer_drop_oldest_core #(
	parameter int BUFFER_SIZE = lrb_pkg::BUFFER_SIZE_DEF,
	parameter int MAX_LINE    = lrb_pkg::MAX_LINE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [10:0] line_length,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  data_byte_res,
	output logic        last,
	output logic        accepted,
	output logic [10:0] lines_discarded,
	output logic [10:0] used_bytes
);
	import lrb_pkg::*;

	localparam int AW = $clog2(BUFFER_SIZE);
	localparam int FW = $clog2(BUFFER_SIZE + 1);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic          out_free;
	logic          res_push;
	result_t       res;

	lrb_store #(
		.DEPTH (BUFFER_SIZE),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	lrb_ctrl #(
		.BUFFER_SIZE (BUFFER_SIZE),
		.MAX_LINE    (MAX_LINE),
		.AW          (AW),
		.FW          (FW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.line_length (line_length),
		.data_byte   (data_byte),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.out_free    (out_free),
		.res_push    (res_push),
		.res         (res)
	);

	lrb_obuf u_obuf (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (res_push),
		.res_in          (res),
		.free            (out_free),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_kind     (result_kind),
		.data_byte_res   (data_byte_res),
		.last            (last),
		.accepted        (accepted),
		.lines_discarded (lines_discarded),
		.used_bytes      (used_bytes)
	);

endmodule

/* hw/rtl/lrb_store.sv */
module lrb_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	// write one byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/lrb_obuf.sv */
module lrb_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lrb_pkg::result_t res_in,
	output logic            free,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      result_kind,
	output logic [7:0]      data_byte_res,
	output logic            last,
	output logic            accepted,
	output logic [10:0]     lines_discarded,
	output logic [10:0]     used_bytes
);
	import lrb_pkg::*;

	logic    valid_q;
	result_t res_q;

	// slot is free when empty or when its beat leaves this cycle
	assign free = !valid_q || !out_stall;

	// hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// load the payload
	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res_in;
		end
	end

	assign out_valid       = valid_q;
	assign result_kind     = res_q.kind;
	assign data_byte_res   = res_q.data;
	assign last            = res_q.last;
	assign accepted        = res_q.accepted;
	assign lines_discarded = res_q.discarded;
	assign used_bytes      = res_q.used;

endmodule

/* hw/rtl/lrb_ctrl.sv */
module lrb_ctrl #(
	parameter int BUFFER_SIZE = lrb_pkg::BUFFER_SIZE_DEF,
	parameter int MAX_LINE    = lrb_pkg::MAX_LINE_DEF,
	parameter int AW          = $clog2(BUFFER_SIZE),
	parameter int FW          = $clog2(BUFFER_SIZE + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       operation,
	input  logic [10:0]      line_length,
	input  logic [7:0]       data_byte,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output logic [7:0]       mem_wdata,
	output logic             mem_re,
	output logic [AW-1:0]    mem_raddr,
	input  logic [7:0]       mem_rdata,
	input  logic             out_free,
	output logic             res_push,
	output lrb_pkg::result_t res
);
	import lrb_pkg::*;

	localparam int NW = $clog2(MAX_LINE);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DTEST,
		ST_DRD,
		ST_DUSE,
		ST_PRD,
		ST_PUSE
	} state_t;

	state_t        state_q, state_d;
	logic [AW-1:0] rd_ptr_q, rd_ptr_d, rd_next;
	logic [AW-1:0] wr_ptr_q, wr_ptr_d, wr_next;
	logic [FW-1:0] fill_q, fill_d, fill_dec;
	logic [FW-1:0] btw_q, btw_d;
	logic [FW-1:0] drop_q, drop_d;
	logic [NW-1:0] n_q, n_d;
	logic [FW-1:0] len_q;
	logic          in_acc;
	logic          too_long;
	logic          stop;

	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;
	assign too_long = 32'(line_length) >= 32'(BUFFER_SIZE);
	assign fill_dec = fill_q - FW'(1);

	// ring pointers wrap at the store size
	assign rd_next = (rd_ptr_q == AW'(BUFFER_SIZE - 1)) ? '0 : rd_ptr_q + AW'(1);
	assign wr_next = (wr_ptr_q == AW'(BUFFER_SIZE - 1)) ? '0 : wr_ptr_q + AW'(1);

	// writes happen only in idle and reads only in a walk, so a read never meets
	// a write of the same cycle
	assign mem_waddr = wr_ptr_q;
	assign mem_wdata = data_byte;
	assign mem_raddr = rd_ptr_q;

	// sequence the operations
	always_comb begin
		state_d  = state_q;
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		fill_d   = fill_q;
		btw_d    = btw_q;
		drop_d   = drop_q;
		n_d      = n_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		res_push = 1'b0;
		res      = '0;
		stop     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (operation)
						OP_BEGIN: begin
							if (too_long) begin
								btw_d    = '0;
								res_push = 1'b1;
								res.kind = RK_STATUS;
								res.last = 1'b1;
								res.used = 11'(fill_q);
							end else begin
								btw_d   = FW'(line_length);
								drop_d  = '0;
								state_d = ST_DTEST;
							end
						end
						OP_BYTE: begin
							if (btw_q != '0 && fill_q < FW'(BUFFER_SIZE)) begin
								mem_we       = 1'b1;
								wr_ptr_d     = wr_next;
								fill_d       = fill_q + FW'(1);
								btw_d        = btw_q - FW'(1);
								res.accepted = 1'b1;
							end
							res_push = 1'b1;
							res.kind = RK_STATUS;
							res.last = 1'b1;
							res.used = 11'(fill_d);
						end
						OP_POP: begin
							if (fill_q == '0) begin
								res_push = 1'b1;
								res.kind = RK_EMPTY;
								res.last = 1'b1;
							end else begin
								n_d     = '0;
								state_d = ST_PRD;
							end
						end
						OP_CLEAR: begin
							rd_ptr_d = '0;
							wr_ptr_d = '0;
							fill_d   = '0;
							btw_d    = '0;
							res_push = 1'b1;
							res.kind = RK_CLEAR;
							res.last = 1'b1;
						end
					endcase
				end
			end
			ST_DTEST: begin
				// drop another line while the new one does not fit
				if (len_q > (FW'(BUFFER_SIZE) - fill_q) && fill_q != '0) begin
					state_d = ST_DRD;
				end else if (out_free) begin
					res_push      = 1'b1;
					res.kind      = RK_STATUS;
					res.last      = 1'b1;
					res.accepted  = 1'b1;
					res.discarded = 11'(drop_q);
					res.used      = 11'(fill_q);
					state_d       = ST_IDLE;
				end
			end
			ST_DRD: begin
				mem_re  = 1'b1;
				state_d = ST_DUSE;
			end
			ST_DUSE: begin
				rd_ptr_d = rd_next;
				fill_d   = fill_dec;
				if (mem_rdata == NEWLINE || fill_dec == '0) begin
					drop_d  = drop_q + FW'(1);
					state_d = ST_DTEST;
				end else begin
					state_d = ST_DRD;
				end
			end
			ST_PRD: begin
				mem_re  = 1'b1;
				state_d = ST_PUSE;
			end
			ST_PUSE: begin
				// emit the byte once the output slot is free
				if (out_free) begin
					stop     = (mem_rdata == NEWLINE) || (fill_dec == '0) ||
						(n_q == NW'(MAX_LINE - 2));
					rd_ptr_d = rd_next;
					fill_d   = fill_dec;
					n_d      = n_q + NW'(1);
					res_push = 1'b1;
					res.kind = RK_BYTE;
					res.data = mem_rdata;
					res.last = stop;
					res.used = 11'(fill_dec);
					state_d  = stop ? ST_IDLE : ST_PRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// hold state, pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
			btw_q    <= '0;
			drop_q   <= '0;
			n_q      <= '0;
		end else begin
			state_q  <= state_d;
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			fill_q   <= fill_d;
			btw_q    <= btw_d;
			drop_q   <= drop_d;
			n_q      <= n_d;
		end
	end

	// latch the announced length
	always_ff @(posedge clk) begin
		if (in_acc && operation == OP_BEGIN) begin
			len_q <= FW'(line_length);
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(BUFFER_SIZE))
		else $error("fill count above store size");
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (fill_q < FW'(BUFFER_SIZE)))
		else $error("byte written into a full store");
	a_read_filled: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (fill_q != '0))
		else $error("store read while empty");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && operation == OP_CLEAR) |=> (fill_q == '0 && btw_q == '0))
		else $error("clear left bytes behind");
	a_pop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSE && !out_free) |=> $stable(rd_ptr_q))
		else $error("pop advanced while the output slot was busy");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import lrb_pkg::*;

	localparam int STORE_BYTES = BUFFER_SIZE_DEF;
	localparam int SB_AW       = $clog2(STORE_BYTES);
	localparam int LINE_CAP    = MAX_LINE_DEF;
	localparam int RANDOM_HALF = 235;

	// one directed stimulus row; the wanted beat is used only when typed is set
	typedef struct packed {
		logic [1:0]  op;
		logic [10:0] len;
		logic [7:0]  dat;
		logic        typed;
		logic [1:0]  want_kind;
		logic        want_acc;
		logic [10:0] want_used;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_BEGIN;
	logic [10:0] line_length = 11'd0;
	logic [7:0]  data_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  data_byte_res;
	logic        last;
	logic        accepted;
	logic [10:0] lines_discarded;
	logic [10:0] used_bytes;

	// shadow of the line store
	logic [7:0]  store_img [0:STORE_BYTES-1];
	int unsigned rd_idx = 0;
	int unsigned wr_idx = 0;
	int unsigned held = 0;
	int unsigned owed = 0;

	result_t     fresh_beats [$];
	result_t     line_results_due [$];
	plan_row_t   plan [$];
	int          errors = 0;
	int          useful_beats = 0;
	logic        calm_in = 1'b0;

	line_ring_buffer_drop_oldest_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.line_length    (line_length),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.data_byte_res  (data_byte_res),
		.last           (last),
		.accepted       (accepted),
		.lines_discarded(lines_discarded),
		.used_bytes     (used_bytes)
	);

	always #1 clk = ~clk;

	function automatic void note_beat(input logic [1:0] kind, input logic [7:0] dat,
		input logic fin, input logic acc, input int unsigned disc, input int unsigned used);
		result_t r;
		r.kind      = kind;
		r.data      = dat;
		r.last      = fin;
		r.accepted  = acc;
		r.discarded = disc[10:0];
		r.used      = used[10:0];
		fresh_beats.push_back(r);
	endfunction

	function automatic logic [7:0] take_oldest();
		logic [7:0] c;
		c = store_img[rd_idx[SB_AW-1:0]];
		rd_idx = (rd_idx + 1) % STORE_BYTES;
		held--;
		return c;
	endfunction

	// work out the beats that one operation produces and advance the shadow
	function automatic void line_store_step(input logic [1:0] op, input logic [10:0] len,
		input logic [7:0] dat);
		int unsigned dropped;
		int          n;
		logic [7:0]  c;
		logic        stop;
		logic        hit_nl;
		fresh_beats.delete();
		dropped = 0;
		n = 0;
		case (op)
			OP_BEGIN: begin
				if (len >= STORE_BYTES) begin
					owed = 0;
					note_beat(RK_STATUS, 8'h00, 1'b1, 1'b0, 0, held);
				end else begin
					// drop whole oldest lines until the new one fits
					while (len > STORE_BYTES - held && held > 0) begin
						hit_nl = 1'b0;
						while (held > 0 && !hit_nl) begin
							c = take_oldest();
							hit_nl = (c == NEWLINE);
						end
						dropped++;
					end
					owed = 32'(len);
					note_beat(RK_STATUS, 8'h00, 1'b1, 1'b1, dropped, held);
				end
			end
			OP_BYTE: begin
				if (owed > 0 && held < STORE_BYTES) begin
					store_img[wr_idx[SB_AW-1:0]] = dat;
					wr_idx = (wr_idx + 1) % STORE_BYTES;
					held++;
					owed--;
					note_beat(RK_STATUS, 8'h00, 1'b1, 1'b1, 0, held);
				end else begin
					note_beat(RK_STATUS, 8'h00, 1'b1, 1'b0, 0, held);
				end
			end
			OP_POP: begin
				if (held == 0) begin
					note_beat(RK_EMPTY, 8'h00, 1'b1, 1'b0, 0, 0);
				end else begin
					// emit through the newline, the line cap or the last held byte
					stop = 1'b0;
					while (held > 0 && n < LINE_CAP - 1 && !stop) begin
						c = take_oldest();
						stop = (c == NEWLINE) || held == 0 || n + 1 >= LINE_CAP - 1;
						note_beat(RK_BYTE, c, stop, 1'b0, 0, held);
						n++;
					end
				end
			end
			OP_CLEAR: begin
				rd_idx = 0;
				wr_idx = 0;
				held = 0;
				owed = 0;
				note_beat(RK_CLEAR, 8'h00, 1'b1, 1'b0, 0, 0);
			end
		endcase
	endfunction

	function automatic void plan_add(input logic [1:0] op, input logic [10:0] len,
		input logic [7:0] dat, input logic typed, input logic [1:0] kind, input logic acc,
		input logic [10:0] used);
		plan_row_t r;
		r.op        = op;
		r.len       = len;
		r.dat       = dat;
		r.typed     = typed;
		r.want_kind = kind;
		r.want_acc  = acc;
		r.want_used = used;
		plan.push_back(r);
	endfunction

	task automatic compare_field(input string name, input logic [10:0] want,
		input logic [10:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// drive one beat after a random gap, hold it until taken, then predict
	task automatic send_beat(input logic [1:0] op, input logic [10:0] len,
		input logic [7:0] dat);
		int gap;
		gap = calm_in ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		line_length <= len;
		data_byte   <= dat;
		do @(posedge clk); while (in_stall !== 1'b0);
		line_store_step(op, len, dat);
		foreach (fresh_beats[i]) line_results_due.push_back(fresh_beats[i]);
		if (!(op == OP_BYTE && !fresh_beats[0].accepted)) useful_beats++;
	endtask

	// hold off the sender until every pending beat has come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (line_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic random_traffic(input int goal);
		int         pick;
		int         sz;
		int         stop_at;
		int         i;
		logic [7:0] b;
		useful_beats = 0;
		while (useful_beats < goal) begin
			if ($urandom_range(0, 39) == 0) calm_in = ~calm_in;
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// one line: mostly short, some past the pop cap, rarely a huge announcement
				case ($urandom_range(0, 19))
					0: sz = 0;
					1, 2, 3: sz = $urandom_range(40, 90);
					4: sz = $urandom_range(300, 1023);
					default: sz = $urandom_range(1, 20);
				endcase
				send_beat(OP_BEGIN, 11'(sz), 8'($urandom_range(0, 255)));
				// cut some lines short; huge announcements carry only a short tail
				stop_at = sz;
				if (sz > 200)
					stop_at = $urandom_range(1, 12);
				else if ($urandom_range(0, 5) == 0)
					stop_at = $urandom_range(0, sz);
				for (i = 0; i < stop_at; i++) begin
					b = 8'($urandom_range(0, 255));
					if (i == sz - 1 && $urandom_range(0, 7) != 0)
						b = NEWLINE;
					else if ($urandom_range(0, 15) == 0)
						b = NEWLINE;
					send_beat(OP_BYTE, 11'($urandom_range(0, 2047)), b);
				end
			end else if (pick < 82) begin
				send_beat(OP_POP, 11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
			end else if (pick < 85) begin
				wait_drained();
			end else if (pick < 88) begin
				send_beat(OP_CLEAR, 11'($urandom_range(0, 2047)),
					8'($urandom_range(0, 255)));
			end else begin
				send_beat(2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)),
					8'($urandom_range(0, 255)));
			end
		end
	endtask

	// check every beat taken from the output against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (line_results_due.size() == 0) begin
				$display("%0t: result beat with none expected: kind %0d byte %h used %0d",
					$time, result_kind, data_byte_res, used_bytes);
				errors++;
			end else begin
				want = line_results_due.pop_front();
				compare_field("result_kind", 11'(want.kind), 11'(result_kind));
				compare_field("data_byte_res", 11'(want.data), 11'(data_byte_res));
				compare_field("last", 11'(want.last), 11'(last));
				compare_field("accepted", 11'(want.accepted), 11'(accepted));
				compare_field("lines_discarded", want.discarded, lines_discarded);
				compare_field("used_bytes", want.used, used_bytes);
			end
		end
	end

	// stall the output for a random count per beat, with calm stretches
	initial begin : result_sink
		int   hold;
		logic calm_out;
		calm_out = 1'b0;
		forever begin
			if ($urandom_range(0, 49) == 0) calm_out = ~calm_out;
			hold = calm_out ? 0 : $urandom_range(0, 4);
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	initial begin : stimulus
		plan_row_t  row;
		result_t    typed_want;
		int         k;
		int         i;
		int         j;
		int         sz;

		// hold reset, then release it on a falling clock edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty store, surplus byte, rejected lengths, largest accepted length, a short line popped
		plan_add(OP_POP,   11'd0,    8'h00, 1'b1, RK_EMPTY,  1'b0, 11'd0);
		plan_add(OP_BYTE,  11'd0,    8'h5A, 1'b1, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BEGIN, 11'd2047, 8'h00, 1'b1, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BEGIN, 11'd1024, 8'hFF, 1'b1, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BEGIN, 11'd1023, 8'h00, 1'b1, RK_STATUS, 1'b1, 11'd0);
		plan_add(OP_BYTE,  11'd0,    8'h41, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BYTE,  11'd0,    8'hFF, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BYTE,  11'd0,    NEWLINE, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BEGIN, 11'd0,    8'h00, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_POP,   11'd0,    8'h00, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_POP,   11'd0,    8'h00, 1'b1, RK_EMPTY,  1'b0, 11'd0);
		// re-announce mid line, then a trailing line with no newline
		plan_add(OP_BEGIN, 11'd3,    8'h00, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BYTE,  11'd0,    8'h61, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BYTE,  11'd0,    8'h00, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BYTE,  11'd0,    8'h62, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BEGIN, 11'd2,    8'h00, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BYTE,  11'd0,    NEWLINE, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BYTE,  11'd0,    8'h78, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BYTE,  11'd0,    8'h33, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_POP,   11'd0,    8'h00, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_POP,   11'd0,    8'h00, 1'b0, RK_STATUS, 1'b0, 11'd0);
		// clear a store that holds data
		plan_add(OP_BEGIN, 11'd2,    8'h00, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_BYTE,  11'd0,    8'h01, 1'b0, RK_STATUS, 1'b0, 11'd0);
		plan_add(OP_CLEAR, 11'd0,    8'h00, 1'b1, RK_CLEAR,  1'b0, 11'd0);
		plan_add(OP_POP,   11'd0,    8'h00, 1'b1, RK_EMPTY,  1'b0, 11'd0);

		for (k = 0; k < plan.size(); k++) begin
			row = plan[k];
			send_beat(row.op, row.len, row.dat);
			// swap the predicted beat for the one typed into the row
			if (row.typed) begin
				typed_want          = '0;
				typed_want.kind     = row.want_kind;
				typed_want.last     = 1'b1;
				typed_want.accepted = row.want_acc;
				typed_want.used     = row.want_used;
				void'(line_results_due.pop_back());
				line_results_due.push_back(typed_want);
			end
		end

		random_traffic(RANDOM_HALF);

		// fill the store to the last byte, push past it, pop, then drop everything
		wait_drained();
		send_beat(OP_CLEAR, 11'd0, 8'h00);
		for (j = 0; j < 2; j++) begin
			sz = (j == 0) ? 994 : 30;
			send_beat(OP_BEGIN, 11'(sz), 8'($urandom_range(0, 255)));
			for (i = 0; i < sz; i++)
				send_beat(OP_BYTE, 11'($urandom_range(0, 2047)),
					(i == sz - 1) ? NEWLINE : 8'($urandom_range(11, 255)));
		end
		send_beat(OP_BYTE, 11'd0, 8'h55);
		send_beat(OP_POP, 11'd0, 8'h00);
		send_beat(OP_BEGIN, 11'd1023, 8'h00);

		random_traffic(RANDOM_HALF);

		wait_drained();
		repeat (300) @(posedge clk);
		if (errors == 0 && line_results_due.size() == 0)
			$display("line_ring_buffer_drop_oldest_core test passed");
		else
			$display("line_ring_buffer_drop_oldest_core test failed");
		$finish;
	end

	initial begin : watchdog
		#20000000;
		$display("line_ring_buffer_drop_oldest_core test failed");
		$finish;
	end

endmodule
